FILE: rtl/slsm_pkg.sv
package slsm_pkg;

    // serial multiplier: operand and product widths
    localparam int MUL_W  = 16;
    localparam int PROD_W = 2 * MUL_W;
    localparam int MCNT_W = $clog2(MUL_W);

    // serial divider: quotient bits (|off| * |dphys| < 2**28) and divisor width
    localparam int QUO_W  = 28;
    localparam int DVS_W  = 12;
    localparam int DCNT_W = $clog2(QUO_W);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CMD_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHYS_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHYS_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_RATE = 3'd4;

endpackage

FILE: rtl/slsm_mul.sv
module slsm_mul
    import slsm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    logic [MUL_W-1:0]  a_reg;
    logic [PROD_W-1:0] p_reg;
    logic [MCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MUL_W:0]    sum;

    // one multiplier bit per cycle, LSB first: add into the upper half, shift right
    always_comb begin
        sum = {1'b0, p_reg[PROD_W-1:MUL_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MCNT_W'(MUL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            p_reg <= {{MUL_W{1'b0}}, b};
        end else if (busy_reg) begin
            p_reg <= {sum, p_reg[MUL_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule

FILE: rtl/slsm_div.sv
module slsm_div
    import slsm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [QUO_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  q_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;

    // restoring step: bring down one dividend bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, q_reg[QUO_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out the top as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            q_reg   <= {q_reg[QUO_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: rtl/slew_limited_servo_model_unit.sv
// Channel  Direction  Ports                                        Handshake
// input    in         s_func, s_command, s_elapsed                 s_valid / s_ready
// result   out        m_position                                   m_valid / m_ready
// config   in         cfg_index, cfg_wdata                         cfg_wr_en (no wait)
//
// A time step runs the bit-serial multiplies (span product and slew step run side
// by side), a hand-off, the bit-serial divide, a hand-off, then target, move and
// result register. s_ready returns with the result, so a new time step is taken
// only once the last one is through. A command write goes straight from idle to
// the result register.
// One word is in flight at a time; a new word is taken while the last result waits.
// aresetn is synchronous and loads the register defaults, command 0, position 0.
// A stalled m_ready holds the finished word in the output register and the block
// waits in its last state before taking the next one.
module slew_limited_servo_model_unit
    import slsm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  logic [11:0]           s_command,
    input  logic [15:0]           s_elapsed,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_position,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_TGT  = 3'd3;
    localparam logic [2:0] S_MOVE = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]         state_reg;
    logic [11:0]        cmd_min_reg;
    logic [11:0]        cmd_max_reg;
    logic signed [15:0] phys_min_reg;
    logic signed [15:0] phys_max_reg;
    logic [14:0]        slew_rate_reg;
    logic [11:0]        held_command_reg;
    logic signed [15:0] position_reg;
    logic signed [15:0] target_reg;
    logic [15:0]        step_reg;
    logic [DVS_W-1:0]   span_mag_reg;
    logic               neg_reg;
    logic               zero_span_reg;
    logic               m_valid_reg;
    logic signed [15:0] m_position_reg;

    logic               accept;
    logic               out_free;
    logic [11:0]        clamped;
    logic signed [12:0] off_s;
    logic signed [12:0] span_s;
    logic signed [16:0] dphys_s;
    logic [12:0]        off_abs;
    logic [12:0]        span_abs;
    logic [16:0]        dphys_abs;
    logic               step_done;
    logic               prod_done;
    logic [PROD_W-1:0]  step_prod;
    logic [PROD_W-1:0]  span_prod;
    logic               div_start;
    logic               div_done;
    logic [QUO_W-1:0]   quot;
    logic signed [QUO_W:0]   q_s;
    logic signed [QUO_W+1:0] tsum;
    logic signed [15:0] tsat;
    logic signed [16:0] pos_ext;
    logic signed [16:0] tgt_ext;
    logic signed [16:0] np_up;
    logic signed [16:0] np_dn;
    logic signed [15:0] pos_next;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // command clamp: test the upper limit first
    always_comb begin
        if (s_command > cmd_max_reg) begin
            clamped = cmd_max_reg;
        end else if (s_command < cmd_min_reg) begin
            clamped = cmd_min_reg;
        end else begin
            clamped = s_command;
        end
    end

    // mapping operands as sign and magnitude
    always_comb begin
        off_s     = $signed({1'b0, held_command_reg}) - $signed({1'b0, cmd_min_reg});
        span_s    = $signed({1'b0, cmd_max_reg}) - $signed({1'b0, cmd_min_reg});
        dphys_s   = 17'(phys_max_reg) - 17'(phys_min_reg);
        off_abs   = off_s[12] ? 13'(-off_s) : 13'(off_s);
        span_abs  = span_s[12] ? 13'(-span_s) : 13'(span_s);
        dphys_abs = dphys_s[16] ? 17'(-dphys_s) : 17'(dphys_s);
    end

    // step = elapsed * slew_rate, kept as unsigned Q16.0 in position units after the >> 16
    slsm_mul u_step_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && s_func),
        .a       (s_elapsed),
        .b       ({1'b0, slew_rate_reg}),
        .done    (step_done),
        .product (step_prod)
    );

    // |held - cmd_min| * |phys_max - phys_min|
    slsm_mul u_span_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && s_func),
        .a       (dphys_abs[MUL_W-1:0]),
        .b       ({{(MUL_W-12){1'b0}}, off_abs[11:0]}),
        .done    (prod_done),
        .product (span_prod)
    );

    assign div_start = (state_reg == S_MUL) && prod_done;

    slsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (span_prod[QUO_W-1:0]),
        .divisor  (span_mag_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // target = sat16(phys_min + signed quotient), truncated toward zero
    always_comb begin
        q_s  = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        tsum = (QUO_W+2)'(phys_min_reg) + (QUO_W+2)'(q_s);
        if ((tsum[QUO_W+1:15] == '0) || (tsum[QUO_W+1:15] == '1)) begin
            tsat = tsum[15:0];
        end else if (tsum[QUO_W+1]) begin
            tsat = 16'sh8000;
        end else begin
            tsat = 16'sh7FFF;
        end
    end

    // slew toward the target, stop on it
    always_comb begin
        pos_ext  = 17'(position_reg);
        tgt_ext  = 17'(target_reg);
        np_up    = pos_ext + $signed({1'b0, step_reg});
        np_dn    = pos_ext - $signed({1'b0, step_reg});
        pos_next = position_reg;
        if (position_reg < target_reg) begin
            pos_next = (np_up > tgt_ext) ? target_reg : np_up[15:0];
        end else if (position_reg > target_reg) begin
            pos_next = (np_dn < tgt_ext) ? target_reg : np_dn[15:0];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_min_reg   <= 12'd1000;
            cmd_max_reg   <= 12'd2000;
            phys_min_reg  <= -16'sd3840;
            phys_max_reg  <= 16'sd3840;
            slew_rate_reg <= 15'd1280;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CMD_MIN:   cmd_min_reg   <= cfg_wdata[11:0];
                REG_CMD_MAX:   cmd_max_reg   <= cfg_wdata[11:0];
                REG_PHYS_MIN:  phys_min_reg  <= cfg_wdata;
                REG_PHYS_MAX:  phys_max_reg  <= cfg_wdata;
                REG_SLEW_RATE: slew_rate_reg <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // sequencer and servo state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            held_command_reg <= '0;
            position_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            // result valid: set on a finished word, cleared when taken
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (s_func) begin
                            state_reg <= S_MUL;
                        end else begin
                            held_command_reg <= clamped;
                            state_reg        <= S_FIN;
                        end
                    end
                end
                S_MUL: begin
                    if (prod_done) begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_TGT;
                    end
                end
                S_TGT: begin
                    state_reg <= S_MOVE;
                end
                S_MOVE: begin
                    position_reg <= pos_next;
                    state_reg    <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept && s_func) begin
            span_mag_reg  <= span_abs[DVS_W-1:0];
            neg_reg       <= off_s[12] ^ dphys_s[16] ^ span_s[12];
            zero_span_reg <= (cmd_max_reg == cmd_min_reg);
        end
        if (state_reg == S_MUL && step_done) begin
            step_reg <= step_prod[PROD_W-1:MUL_W];
        end
        if (state_reg == S_TGT) begin
            target_reg <= zero_span_reg ? phys_min_reg : tsat;
        end
        if (state_reg == S_FIN && out_free) begin
            m_position_reg <= position_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;

    // position only moves in the move state
    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) != S_MOVE) |-> $stable(position_reg))
        else $error("position changed outside move state");

    // a new result word only comes out of the final state
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result raised outside final state");

    // a move never passes the target
    a_no_overshoot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOVE) |=>
        (($past(position_reg) <= $past(target_reg)) ?
            (position_reg >= $past(position_reg) && position_reg <= $past(target_reg)) :
            (position_reg <= $past(position_reg) && position_reg >= $past(target_reg))))
        else $error("position overshot target");

    // with ordered limits a stored command lies inside them
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_func && cmd_min_reg <= cmd_max_reg) |=>
        (held_command_reg >= cmd_min_reg && held_command_reg <= cmd_max_reg))
        else $error("held command outside limits");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import slsm_pkg::*;

    localparam logic FUNC_COMMAND = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;
    localparam int   CYCLE_LIMIT  = 2_000_000;
    localparam int   PRINT_CAP    = 100;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_func;
    logic [11:0]           s_command;
    logic [15:0]           s_elapsed;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [15:0]    m_position;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    slew_limited_servo_model_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_command  (s_command),
        .s_elapsed  (s_elapsed),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_position (m_position),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // predictor copy of registers and servo state
    logic [11:0]        lim_cmd_min;
    logic [11:0]        lim_cmd_max;
    logic signed [15:0] rng_phys_min;
    logic signed [15:0] rng_phys_max;
    logic [14:0]        slew_q88;
    logic [11:0]        held_cmd;
    logic signed [15:0] cur_pos;

    logic signed [15:0] position_due[$];
    int                 err_count;
    int                 accepted_words;
    int                 cycle_count;
    bit                 idle_on;
    bit                 stall_on;

    // target from held command: linear map, truncate toward zero, saturate
    function automatic longint servo_target();
        longint span;
        longint off;
        longint q;
        longint t;
        span = longint'(lim_cmd_max) - longint'(lim_cmd_min);
        if (span == 0) begin
            return longint'(rng_phys_min);
        end
        off = longint'(held_cmd) - longint'(lim_cmd_min);
        q = (off * (longint'(rng_phys_max) - longint'(rng_phys_min))) / span;
        t = longint'(rng_phys_min) + q;
        if (t > 32767) begin
            t = 32767;
        end else if (t < -32768) begin
            t = -32768;
        end
        return t;
    endfunction

    // apply one word to the predictor, return the position it reports
    function automatic logic signed [15:0] servo_next_position(logic func,
                                                               logic [11:0] command,
                                                               logic [15:0] elapsed);
        longint tgt;
        longint stp;
        longint np;
        if (func == FUNC_COMMAND) begin
            if (command > lim_cmd_max) begin
                held_cmd = lim_cmd_max;
            end else if (command < lim_cmd_min) begin
                held_cmd = lim_cmd_min;
            end else begin
                held_cmd = command;
            end
        end else begin
            tgt = servo_target();
            stp = (longint'(elapsed) * longint'(slew_q88)) >> 16;
            if (longint'(cur_pos) < tgt) begin
                np = longint'(cur_pos) + stp;
                cur_pos = 16'((np > tgt) ? tgt : np);
            end else if (longint'(cur_pos) > tgt) begin
                np = longint'(cur_pos) - stp;
                cur_pos = 16'((np < tgt) ? tgt : np);
            end
        end
        return cur_pos;
    endfunction

    task automatic report_mismatch(string msg);
        if (err_count < PRINT_CAP) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        err_count++;
    endtask

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 16);
        return $urandom_range(30, 100);
    endfunction

    // input acceptance: predict at the edge the word is taken
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            position_due.push_back(servo_next_position(s_func, s_command, s_elapsed));
            accepted_words++;
        end
    end

    // result check against oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (position_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word, position %0d", m_position));
            end else begin
                if (m_position !== position_due[0]) begin
                    report_mismatch($sformatf("position got %0d want %0d",
                                              m_position, position_due[0]));
                end
                void'(position_due.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("slew_limited_servo_model_unit: mismatch");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int n;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (stall_on && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                n = pick_gap();
                if (n == 0) n = 1;
                repeat (n) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(negedge aclk);
        end
    end

    // send one word, hold until taken, then maybe idle
    task automatic send_word(logic func, logic [11:0] command, logic [15:0] elapsed);
        int n;
        int g;
        n = accepted_words;
        s_func    = func;
        s_command = command;
        s_elapsed = elapsed;
        s_valid   = 1'b1;
        do @(negedge aclk); while (accepted_words == n);
        if (idle_on) begin
            g = pick_gap();
            if (g > 0) begin
                s_valid = 1'b0;
                repeat (g) @(negedge aclk);
            end
        end
    endtask

    // stop sending and wait for every result
    task automatic wait_drained();
        s_valid = 1'b0;
        while (position_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        case (idx)
            REG_CMD_MIN:   lim_cmd_min  = data[11:0];
            REG_CMD_MAX:   lim_cmd_max  = data[11:0];
            REG_PHYS_MIN:  rng_phys_min = data;
            REG_PHYS_MAX:  rng_phys_max = data;
            REG_SLEW_RATE: slew_q88     = data[14:0];
            default: ;
        endcase
    endtask

    // only called with the block idle
    task automatic set_config(logic [11:0] cmin, logic [11:0] cmax,
                              logic signed [15:0] pmin, logic signed [15:0] pmax,
                              logic [14:0] slew);
        write_reg(REG_CMD_MIN, 16'(cmin));
        write_reg(REG_CMD_MAX, 16'(cmax));
        write_reg(REG_PHYS_MIN, pmin);
        write_reg(REG_PHYS_MAX, pmax);
        write_reg(REG_SLEW_RATE, 16'(slew));
        cfg_wr_en = 1'b0;
    endtask

    // reset registers, held command 0 extrapolated, clamping, zero step
    task automatic test_reset_state();
        idle_on  = 1'b1;
        stall_on = 1'b1;
        send_word(FUNC_ADVANCE, 12'd0, 16'd0);
        send_word(FUNC_ADVANCE, 12'd0, 16'hFFFF);
        send_word(FUNC_COMMAND, 12'd0, 16'd0);
        send_word(FUNC_COMMAND, 12'hFFF, 16'hFFFF);
        send_word(FUNC_ADVANCE, 12'd0, 16'hFFFF);
        send_word(FUNC_COMMAND, 12'd1500, 16'd0);
        send_word(FUNC_ADVANCE, 12'hFFF, 16'd1);
        send_word(FUNC_ADVANCE, 12'd0, 16'hFFFF);
        wait_drained();
    endtask

    // equal limits, reversed limits, extrapolation with saturation, zero slew
    task automatic test_limit_cases();
        set_config(12'd2048, 12'd2048, -16'sd32768, 16'sd32767, 15'h7FFF);
        send_word(FUNC_COMMAND, 12'hFFF, 16'd0);
        send_word(FUNC_ADVANCE, 12'd0, 16'hFFFF);
        send_word(FUNC_ADVANCE, 12'd0, 16'hFFFF);
        send_word(FUNC_ADVANCE, 12'd0, 16'd0);
        wait_drained();
        set_config(12'd3000, 12'd100, 16'sd32767, -16'sd32768, 15'h7FFF);
        send_word(FUNC_COMMAND, 12'd2000, 16'd0);
        send_word(FUNC_COMMAND, 12'd50, 16'd0);
        send_word(FUNC_COMMAND, 12'd0, 16'd0);
        send_word(FUNC_ADVANCE, 12'd0, 16'hFFFF);
        send_word(FUNC_COMMAND, 12'd2000, 16'd0);
        send_word(FUNC_ADVANCE, 12'd0, 16'hFFFF);
        wait_drained();
        set_config(12'd4000, 12'hFFF, -16'sd32768, 16'sd32767, 15'd0);
        send_word(FUNC_ADVANCE, 12'd0, 16'hFFFF);
        wait_drained();
        set_config(12'd0, 12'd1, -16'sd32768, 16'sd32767, 15'h7FFF);
        send_word(FUNC_ADVANCE, 12'd0, 16'hFFFF);
        send_word(FUNC_ADVANCE, 12'd0, 16'hFFFF);
        send_word(FUNC_COMMAND, 12'hFFF, 16'd0);
        send_word(FUNC_ADVANCE, 12'd0, 16'd40000);
        wait_drained();
    endtask

    // random words over a range of register settings
    task automatic test_random_phases();
        logic [11:0]        cmin;
        logic [11:0]        cmax;
        logic signed [15:0] pmin;
        logic signed [15:0] pmax;
        logic [14:0]        slew;
        logic [11:0]        cmd;
        logic [15:0]        el;
        int                 r;
        for (int p = 0; p < 12; p++) begin
            cmin = 12'($urandom_range(0, 2000));
            cmax = 12'(cmin + $urandom_range(1, 2095));
            pmin = 16'($urandom);
            pmax = 16'($urandom);
            slew = 15'($urandom);
            case (p % 6)
                0: begin
                    cmin = 12'd0;
                    cmax = 12'hFFF;
                    pmin = -16'sd32768;
                    pmax = 16'sd32767;
                    slew = (p == 0) ? 15'h7FFF : 15'($urandom_range(1, 400));
                end
                1: begin
                    pmin = 16'sd32767;
                    pmax = -16'sd32768;
                end
                3: cmax = cmin;
                4: cmax = 12'($urandom_range(0, cmin));
                5: slew = (p == 5) ? 15'd0 : 15'($urandom_range(0, 300));
                default: ;
            endcase
            set_config(cmin, cmax, pmin, pmax, slew);
            idle_on  = (p % 4 != 3);
            stall_on = (p % 4 < 2);
            for (int i = 0; i < 105; i++) begin
                r = $urandom_range(0, 99);
                case ($urandom_range(0, 3))
                    0: cmd = lim_cmd_min;
                    1: cmd = lim_cmd_max;
                    2: cmd = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'd0;
                    default: cmd = 12'($urandom);
                endcase
                if ($urandom_range(0, 9) < 6) cmd = 12'($urandom);
                if (r < 60) begin
                    el = 16'($urandom_range(0, 2047));
                end else if (r < 85) begin
                    el = 16'($urandom);
                end else begin
                    case ($urandom_range(0, 2))
                        0: el = 16'd0;
                        1: el = 16'd1;
                        default: el = 16'hFFFF;
                    endcase
                end
                send_word(($urandom_range(0, 9) < 3) ? FUNC_COMMAND : FUNC_ADVANCE, cmd, el);
                // hold the sender until the pipeline is empty now and then
                if (i == 52) wait_drained();
            end
            wait_drained();
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_func         = FUNC_COMMAND;
        s_command      = '0;
        s_elapsed      = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_CMD_MIN;
        cfg_wdata      = '0;
        err_count      = 0;
        accepted_words = 0;
        cycle_count    = 0;
        idle_on        = 1'b0;
        stall_on       = 1'b0;
        lim_cmd_min    = 12'd1000;
        lim_cmd_max    = 12'd2000;
        rng_phys_min   = -16'sd3840;
        rng_phys_max   = 16'sd3840;
        slew_q88       = 15'd1280;
        held_cmd       = '0;
        cur_pos        = '0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_limit_cases();
        test_random_phases();

        wait_drained();
        repeat (60) @(negedge aclk);
        if (position_due.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", position_due.size()));
        end
        if (err_count == 0) begin
            $display("slew_limited_servo_model_unit: match");
        end else begin
            $display("slew_limited_servo_model_unit: mismatch");
        end
        $finish;
    end

endmodule
